// File: hw/rtl/slink_pkg.sv
// Shared types, codes and constants of the segmented stop-and-wait link.
package slink_pkg;

    localparam int SEQ_W   = 16;
    localparam int LEN_W   = 11;
    localparam int TRIES_W = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_SEGMENT_BYTES_DEF = 1024;

    // Input actions.
    localparam logic [2:0] ACT_RX_SEG   = 3'd0;
    localparam logic [2:0] ACT_TX_SEG   = 3'd1;
    localparam logic [2:0] ACT_RX_ACK   = 3'd2;
    localparam logic [2:0] ACT_TICK     = 3'd3;
    localparam logic [2:0] ACT_SHUTDOWN = 3'd4;

    // Result kinds.
    localparam logic [2:0] KIND_DELIVER   = 3'd0;
    localparam logic [2:0] KIND_SEND_ACK  = 3'd1;
    localparam logic [2:0] KIND_SEND_SEG  = 3'd2;
    localparam logic [2:0] KIND_TX_DONE   = 3'd3;
    localparam logic [2:0] KIND_TX_FAILED = 3'd4;
    localparam logic [2:0] KIND_RX_ERROR  = 3'd5;
    localparam logic [2:0] KIND_BUSY      = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_AND_WAIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MODULUS   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES     = 4'd3;

    // Register reset values.
    localparam logic               RST_STOP_AND_WAIT = 1'b1;
    localparam logic [SEQ_W-1:0]   RST_SEQ_MODULUS   = 16'd256;
    localparam logic [15:0]        RST_TIMEOUT_TICKS = 16'd200;
    localparam logic [TRIES_W-1:0] RST_MAX_TRIES     = 4'd5;

    typedef struct packed {
        logic [2:0]       action;
        logic [SEQ_W-1:0] seq_num;
        logic             seg_first;
        logic             seg_last;
        logic [LEN_W-1:0] frame_len;
    } t_item;

    typedef struct packed {
        logic [2:0]       kind;
        logic [SEQ_W-1:0] out_seq;
        logic             out_first;
        logic             out_last;
        logic [LEN_W-1:0] out_len;
        logic             stream_dead;
        logic             last_of_run;
    } t_result;

    // Up to two result words produced by one step.
    typedef struct packed {
        logic [1:0]      cnt;
        t_result [1:0]   res;
    } t_push;

endpackage

// File: hw/rtl/stop_and_wait_segment_link.sv
// Top level of the segmented stop-and-wait link endpoint.
//
//  Channel  Direction  Handshake                  Word
//  in       to block   i_in_valid / o_in_ready    action, seq, marks, frame length
//  out      from block o_out_valid / i_out_ready  kind, seq, marks, length, flags
//  cfg      to block   i_cfg_valid / o_cfg_ready  register index and data
//
// An input word is registered, then processed into zero, one or two result words
// that go into a four-word queue, so one word is taken per cycle while the queue
// has room for two and no recompute runs. Results leave at one word per cycle
// while i_out_ready is high. A seq_modulus write starts a recompute of successor
// numbers in the two bit-serial remainder units; o_cfg_ready stays low then, as does
// o_in_ready while a word is held. Synchronous active-low reset restores control state.
// A stall on the output side fills the queue and then holds o_in_ready low.
module stop_and_wait_segment_link #(
    parameter int MAX_SEGMENT_BYTES = slink_pkg::MAX_SEGMENT_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_action,
    input  logic [slink_pkg::SEQ_W-1:0]      i_seq_num,
    input  logic                             i_seg_first,
    input  logic                             i_seg_last,
    input  logic [slink_pkg::LEN_W-1:0]      i_frame_len,

    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [2:0]                       o_kind,
    output logic [slink_pkg::SEQ_W-1:0]      o_out_seq,
    output logic                             o_out_first,
    output logic                             o_out_last,
    output logic [slink_pkg::LEN_W-1:0]      o_out_len,
    output logic                             o_stream_dead,
    output logic                             o_last_of_run,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [slink_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slink_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import slink_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    step;
    logic    busy;
    logic    q_room;
    t_push   push;
    t_result word;

    assign step       = r_in_valid && q_room && !busy;
    assign o_in_ready = !r_in_valid || step;
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item.action    <= i_action;
            r_in_item.seq_num   <= i_seq_num;
            r_in_item.seg_first <= i_seg_first;
            r_in_item.seg_last  <= i_seg_last;
            r_in_item.frame_len <= i_frame_len;
        end
    end

    slink_core #(
        .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in_item),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_push      (push)
    );

    slink_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (q_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (word)
    );

    assign o_kind        = word.kind;
    assign o_out_seq     = word.out_seq;
    assign o_out_first   = word.out_first;
    assign o_out_last    = word.out_last;
    assign o_out_len     = word.out_len;
    assign o_stream_dead = word.stream_dead;
    assign o_last_of_run = word.last_of_run;

endmodule

// File: hw/rtl/slink_mod.sv
// Bit-serial remainder unit used to re-derive successor sequence numbers.
module slink_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [15:0] o_rem
);
    localparam int STEPS = 17;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_rem;
    logic [16:0]      r_dvd;
    logic [16:0]      r_dvs;

    logic [16:0] trial;
    logic [15:0] n_rem;

    // Restoring step: bring in one dividend bit, subtract the divisor if it fits.
    // The partial remainder stays below the divisor, so it fits in 16 bits.
    always_comb begin
        trial = {r_rem, r_dvd[16]};
        if (trial >= r_dvs) begin
            n_rem = 16'(trial - r_dvs);
        end else begin
            n_rem = trial[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[15:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == CNT_W'(STEPS - 1));
    assign o_rem  = n_rem;

endmodule

// File: hw/rtl/slink_core.sv
// Link state, configuration registers and the combinational step logic.
module slink_core #(
    parameter int MAX_SEGMENT_BYTES = slink_pkg::MAX_SEGMENT_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  slink_pkg::t_item                 i_item,
    input  logic                             i_cfg_wr,
    input  logic [slink_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slink_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                             o_busy,
    output slink_pkg::t_push                 o_push
);
    import slink_pkg::*;

    localparam logic [16:0] RX_LEN_MAX = 17'(MAX_SEGMENT_BYTES + 1);
    localparam logic [16:0] TX_LEN_MAX = 17'(MAX_SEGMENT_BYTES);

    // Configuration.
    logic               r_stop_and_wait;
    logic [SEQ_W-1:0]   r_seq_modulus;
    logic [15:0]        r_timeout_ticks;
    logic [TRIES_W-1:0] r_max_tries;
    logic               r_recalc_start;

    // Link state. The succ registers hold next_seq() of rx_expected and tx_next.
    logic [SEQ_W-1:0]   r_rx_exp, n_rx_exp;
    logic [SEQ_W-1:0]   r_rx_succ, n_rx_succ;
    logic               r_rx_mid, n_rx_mid;
    logic               r_aborted, n_aborted;
    logic [SEQ_W-1:0]   r_tx_next, n_tx_next;
    logic [SEQ_W-1:0]   r_tx_succ, n_tx_succ;
    logic               r_tx_mid, n_tx_mid;
    logic               r_awaiting, n_awaiting;
    logic [LEN_W-1:0]   r_pend_len, n_pend_len;
    logic               r_pend_last, n_pend_last;
    logic [TRIES_W-1:0] r_tries, n_tries;
    logic [15:0]        r_timer, n_timer;

    logic [16:0] mod_eff;
    logic        rx_busy, rx_done, tx_busy, tx_done;
    logic [15:0] rx_rem, tx_rem;

    // A seq_modulus of zero means 65536.
    assign mod_eff = (r_seq_modulus == '0) ? 17'h10000 : {1'b0, r_seq_modulus};

    function automatic logic [SEQ_W-1:0] succ_inc(input logic [SEQ_W-1:0] s,
                                                  input logic [16:0] m);
        logic [16:0] t;
        t = {1'b0, s} + 17'd1;
        return (t == m) ? '0 : t[SEQ_W-1:0];
    endfunction

    // After a modulus write both successors are recomputed from scratch.
    slink_mod u_rx_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_recalc_start),
        .i_dividend ({1'b0, r_rx_exp} + 17'd1),
        .i_divisor  (mod_eff),
        .o_busy     (rx_busy),
        .o_done     (rx_done),
        .o_rem      (rx_rem)
    );

    slink_mod u_tx_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_recalc_start),
        .i_dividend ({1'b0, r_tx_next} + 17'd1),
        .i_divisor  (mod_eff),
        .o_busy     (tx_busy),
        .o_done     (tx_done),
        .o_rem      (tx_rem)
    );

    assign o_busy = r_recalc_start || rx_busy || tx_busy;

    always_comb begin
        logic             bad;
        logic [LEN_W-1:0] tx_len;
        logic [TRIES_W-1:0] lim;
        t_result          ack;
        t_result          res0;
        t_result          res1;
        logic [1:0]       cnt;

        n_rx_exp    = r_rx_exp;
        n_rx_succ   = r_rx_succ;
        n_rx_mid    = r_rx_mid;
        n_aborted   = r_aborted;
        n_tx_next   = r_tx_next;
        n_tx_succ   = r_tx_succ;
        n_tx_mid    = r_tx_mid;
        n_awaiting  = r_awaiting;
        n_pend_len  = r_pend_len;
        n_pend_last = r_pend_last;
        n_tries     = r_tries;
        n_timer     = r_timer;
        res0 = '0;
        res1 = '0;
        ack  = '0;
        cnt  = 2'd0;

        bad = (i_item.frame_len == '0)
              || ({6'd0, i_item.frame_len} > RX_LEN_MAX)
              || (i_item.seq_num != r_rx_exp)
              || (r_rx_mid == i_item.seg_first);
        tx_len = ({6'd0, i_item.frame_len} > TX_LEN_MAX) ? LEN_W'(TX_LEN_MAX)
                                                          : i_item.frame_len;
        lim = (r_max_tries == '0) ? TRIES_W'(1) : r_max_tries;

        case (i_item.action)
            ACT_RX_SEG: begin
                if (!r_aborted) begin
                    cnt = 2'd1;
                    res0.out_seq = i_item.seq_num;
                    if (bad) begin
                        n_aborted = 1'b1;
                        res0.kind = KIND_RX_ERROR;
                    end else begin
                        n_rx_mid     = !i_item.seg_last;
                        n_rx_exp     = r_rx_succ;
                        n_rx_succ    = succ_inc(r_rx_succ, mod_eff);
                        res0.kind    = KIND_DELIVER;
                        res0.out_len = i_item.frame_len - 1'b1;
                    end
                end
                // Every received segment is acknowledged in stop-and-wait mode.
                if (r_stop_and_wait) begin
                    ack.kind    = KIND_SEND_ACK;
                    ack.out_seq = i_item.seq_num;
                    if (cnt == 2'd0) begin
                        res0 = ack;
                    end else begin
                        res1 = ack;
                    end
                    cnt = cnt + 2'd1;
                end
            end
            ACT_TX_SEG: begin
                res0.out_seq = r_tx_next;
                if (r_aborted) begin
                    cnt = 2'd1;
                    res0.kind = KIND_TX_FAILED;
                end else if (r_awaiting) begin
                    cnt = 2'd1;
                    res0.kind = KIND_BUSY;
                end else if (i_item.frame_len != '0) begin
                    cnt = 2'd1;
                    res0.kind      = KIND_SEND_SEG;
                    res0.out_first = !r_tx_mid;
                    res0.out_last  = i_item.seg_last;
                    res0.out_len   = tx_len;
                    if (r_stop_and_wait) begin
                        n_awaiting  = 1'b1;
                        n_pend_len  = tx_len;
                        n_pend_last = i_item.seg_last;
                        n_tries     = TRIES_W'(1);
                        n_timer     = r_timeout_ticks;
                    end else begin
                        cnt = 2'd2;
                        res1.kind    = KIND_TX_DONE;
                        res1.out_seq = r_tx_next;
                        n_tx_mid     = !i_item.seg_last;
                        n_tx_next    = r_tx_succ;
                        n_tx_succ    = succ_inc(r_tx_succ, mod_eff);
                    end
                end
            end
            ACT_RX_ACK: begin
                if (r_awaiting && (i_item.seq_num == r_tx_next)) begin
                    cnt = 2'd1;
                    res0.kind    = KIND_TX_DONE;
                    res0.out_seq = r_tx_next;
                    n_awaiting   = 1'b0;
                    n_tx_mid     = !r_pend_last;
                    n_tx_next    = r_tx_succ;
                    n_tx_succ    = succ_inc(r_tx_succ, mod_eff);
                end
            end
            ACT_TICK: begin
                if (r_awaiting) begin
                    if (r_timer <= 16'd1) begin
                        cnt = 2'd1;
                        res0.out_seq = r_tx_next;
                        if (r_tries >= lim) begin
                            n_aborted  = 1'b1;
                            n_awaiting = 1'b0;
                            n_timer    = '0;
                            res0.kind  = KIND_TX_FAILED;
                        end else begin
                            n_tries        = r_tries + 1'b1;
                            n_timer        = r_timeout_ticks;
                            res0.kind      = KIND_SEND_SEG;
                            res0.out_first = !r_tx_mid;
                            res0.out_last  = r_pend_last;
                            res0.out_len   = r_pend_len;
                        end
                    end else begin
                        n_timer = r_timer - 1'b1;
                    end
                end
            end
            ACT_SHUTDOWN: begin
                n_aborted = 1'b1;
                if (r_awaiting) begin
                    cnt = 2'd1;
                    n_awaiting   = 1'b0;
                    n_timer      = '0;
                    res0.kind    = KIND_TX_FAILED;
                    res0.out_seq = r_tx_next;
                end
            end
            default: begin
            end
        endcase

        res0.stream_dead = n_aborted;
        res1.stream_dead = n_aborted;
        res0.last_of_run = (cnt == 2'd1);
        res1.last_of_run = 1'b1;

        o_push.cnt    = i_step ? cnt : 2'd0;
        o_push.res[0] = res0;
        o_push.res[1] = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_and_wait <= RST_STOP_AND_WAIT;
            r_seq_modulus   <= RST_SEQ_MODULUS;
            r_timeout_ticks <= RST_TIMEOUT_TICKS;
            r_max_tries     <= RST_MAX_TRIES;
            r_recalc_start  <= 1'b0;
        end else begin
            r_recalc_start <= 1'b0;
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_STOP_AND_WAIT: r_stop_and_wait <= i_cfg_data[0];
                    CFG_SEQ_MODULUS: begin
                        r_seq_modulus  <= i_cfg_data;
                        r_recalc_start <= 1'b1;
                    end
                    CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                    CFG_MAX_TRIES:     r_max_tries     <= i_cfg_data[TRIES_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_exp    <= '0;
            r_rx_succ   <= SEQ_W'(1);
            r_rx_mid    <= 1'b0;
            r_aborted   <= 1'b0;
            r_tx_next   <= '0;
            r_tx_succ   <= SEQ_W'(1);
            r_tx_mid    <= 1'b0;
            r_awaiting  <= 1'b0;
            r_pend_len  <= '0;
            r_pend_last <= 1'b0;
            r_tries     <= '0;
            r_timer     <= '0;
        end else begin
            if (i_step) begin
                r_rx_exp    <= n_rx_exp;
                r_rx_succ   <= n_rx_succ;
                r_rx_mid    <= n_rx_mid;
                r_aborted   <= n_aborted;
                r_tx_next   <= n_tx_next;
                r_tx_succ   <= n_tx_succ;
                r_tx_mid    <= n_tx_mid;
                r_awaiting  <= n_awaiting;
                r_pend_len  <= n_pend_len;
                r_pend_last <= n_pend_last;
                r_tries     <= n_tries;
                r_timer     <= n_timer;
            end
            if (rx_done) begin
                r_rx_succ <= rx_rem;
            end
            if (tx_done) begin
                r_tx_succ <= tx_rem;
            end
        end
    end

`ifndef SYNTHESIS
    a_abort_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_aborted |=> r_aborted)
        else $error("abort flag cleared without reset");

    a_succ_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> (({1'b0, r_rx_succ} < mod_eff) && ({1'b0, r_tx_succ} < mod_eff)))
        else $error("successor sequence number outside the modulus");

    a_wait_has_try: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> (r_tries != '0))
        else $error("waiting for an ack with no attempt counted");
`endif

endmodule

// File: hw/rtl/slink_outq.sv
// Four-word result queue: takes up to two words a cycle, hands out one while i_ready is high.
module slink_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slink_pkg::t_push   i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output slink_pkg::t_result o_word
);
    import slink_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_1;

    assign o_valid  = (r_count != '0);
    assign o_word   = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;
    // Room means space for the largest burst one step can produce.
    assign o_room   = (r_count <= CNT_W'(DEPTH - 2));
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res[0];
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (r_count <= CNT_W'(DEPTH - 2)))
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue count beyond its depth");
`endif

endmodule
